[rtl/assert_macros.svh]
// Assertion macros shared by the RTL files of the key-value cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)

`endif

`endif

[rtl/lkvc_pkg.sv]
// Package with the shared constants and operation codes of the key-value cache.
package lkvc_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT   = 32;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Capacity register
   localparam int             CAP_BITS  = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   // Operation codes carried in req_tuser
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_STORE  = 1'b1;

endpackage

[rtl/lru_key_value_cache.sv]
// Fully associative key-value cache with least-recently-used replacement.
// A lookup is held in the input register, and its result then in the response register.
// Throughput: one transaction per cycle unless a lookup waits for the response register to
// free; the tag compare over all entries and the rank update are combinational between the two.
// Reset (synchronous, active high) empties the cache and sets capacity to 16;
// stored keys and values are not cleared.
`include "assert_macros.svh"

module lru_key_value_cache #(
   parameter int ENTRIES    = lkvc_pkg::ENTRIES_DEFAULT,
   parameter int KEY_BITS   = lkvc_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS = lkvc_pkg::VALUE_BITS_DEFAULT,
   localparam int REQ_BITS  = ((KEY_BITS + 2 * VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS  = ((VALUE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata, low bit up: key, store_value, fallback_value, zero fill
   input  logic [REQ_BITS-1:0]           req_tdata,
   // tuser: kind (0 lookup, 1 store)
   input  logic                          req_tuser,
   // Response channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata, low bit up: read_value, zero fill
   output logic [RSP_BITS-1:0]           rsp_tdata,
   // tuser: hit
   output logic                          rsp_tuser,
   // Capacity register write port
   input  logic                          csr_wr_en,
   input  logic [lkvc_pkg::CAP_BITS-1:0] csr_wr_data
);

   localparam int RANK_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_BITS = $clog2(ENTRIES + 1);
   localparam int CMP_BITS   = (COUNT_BITS > lkvc_pkg::CAP_BITS) ? COUNT_BITS
                                                                 : lkvc_pkg::CAP_BITS;

   typedef logic [RANK_BITS-1:0] rank_type;

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic                  s1_valid_ff;
   logic                  s1_kind_ff;
   logic [KEY_BITS-1:0]   s1_key_ff;
   logic [VALUE_BITS-1:0] s1_sval_ff;
   logic [VALUE_BITS-1:0] s1_fval_ff;
   logic                  s1_valid_in;
   logic                  s1_fire;

   // Response register
   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_valid_in;

   // Cache state
   logic [ENTRIES-1:0]    entry_valid_ff;
   logic [ENTRIES-1:0]    entry_valid_in;
   rank_type              entry_rank_ff [ENTRIES];
   rank_type              entry_rank_in [ENTRIES];
   logic [KEY_BITS-1:0]   entry_key_ff  [ENTRIES];
   logic [VALUE_BITS-1:0] entry_data_ff [ENTRIES];
   logic [COUNT_BITS-1:0] occ_ff;
   logic [COUNT_BITS-1:0] occ_in;
   logic [lkvc_pkg::CAP_BITS-1:0] cap_ff;

   // Lookup and update logic
   logic [ENTRIES-1:0]    match_vec;
   logic [ENTRIES-1:0]    evict_sel;
   logic [ENTRIES-1:0]    free_vec;
   logic [ENTRIES-1:0]    ins_onehot;
   logic [ENTRIES-1:0]    key_we;
   logic [ENTRIES-1:0]    data_we;
   logic                  hit;
   rank_type              hit_rank;
   logic [VALUE_BITS-1:0] hit_value;
   logic [COUNT_BITS-1:0] occ_m1;
   logic [CMP_BITS-1:0]   eff_cap;
   logic                  cap_zero;
   logic                  full;
   logic                  do_store;
   logic                  do_promote;
   logic                  do_insert;
   logic                  do_evict;

   // ---------------------------------------------------------------------
   // Handshake: a store never waits on the response side; a lookup needs
   // the response register free or draining this cycle.
   // ---------------------------------------------------------------------
   assign s1_fire = s1_valid_ff &&
                    ((s1_kind_ff == lkvc_pkg::KIND_STORE) || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_fire;
   assign s1_valid_in = req_tready ? req_tvalid : s1_valid_ff;

   always_comb begin
      if (s1_fire && (s1_kind_ff == lkvc_pkg::KIND_LOOKUP)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Tag compare across all entries. Valid keys are unique, so at most one
   // entry matches and an OR of the masked fields selects it.
   // ---------------------------------------------------------------------
   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_vec[i] = entry_valid_ff[i] && (entry_key_ff[i] == s1_key_ff);
         if (match_vec[i]) begin
            hit_rank  = hit_rank | entry_rank_ff[i];
            hit_value = hit_value | entry_data_ff[i];
         end
      end
      hit = |match_vec;
   end

   // Capacity above the entry count saturates to the entry count.
   always_comb begin
      if (CMP_BITS'(cap_ff) > CMP_BITS'(ENTRIES)) begin
         eff_cap = CMP_BITS'(ENTRIES);
      end else begin
         eff_cap = CMP_BITS'(cap_ff);
      end
   end

   assign cap_zero = (eff_cap == '0);
   assign full     = (CMP_BITS'(occ_ff) >= eff_cap);
   assign occ_m1   = occ_ff - COUNT_BITS'(1);

   assign do_store   = s1_fire && (s1_kind_ff == lkvc_pkg::KIND_STORE) && !cap_zero;
   assign do_promote = s1_fire && hit &&
                       ((s1_kind_ff == lkvc_pkg::KIND_LOOKUP) || do_store);
   assign do_insert  = do_store && !hit;
   assign do_evict   = do_insert && full;

   // Oldest entry carries rank occupied-1; the insert goes to the lowest
   // free slot once that entry is released.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         evict_sel[i] = entry_valid_ff[i] &&
                        (entry_rank_ff[i] == occ_m1[RANK_BITS-1:0]);
      end
   end

   assign free_vec   = ~entry_valid_ff | (do_evict ? evict_sel : '0);
   assign ins_onehot = free_vec & (~free_vec + ENTRIES'(1));

   // ---------------------------------------------------------------------
   // Next state of valid bits and recency ranks
   // ---------------------------------------------------------------------
   always_comb begin
      entry_valid_in = entry_valid_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_rank_in[i] = entry_rank_ff[i];
         if (do_promote) begin
            // Move the hit entry to the front; age everything more recent.
            if (match_vec[i]) begin
               entry_rank_in[i] = '0;
            end else if (entry_valid_ff[i] && (entry_rank_ff[i] < hit_rank)) begin
               entry_rank_in[i] = entry_rank_ff[i] + RANK_BITS'(1);
            end
         end
         if (do_insert) begin
            if (do_evict && evict_sel[i]) begin
               entry_valid_in[i] = 1'b0;
               entry_rank_in[i]  = '0;
            end else if (entry_valid_ff[i]) begin
               entry_rank_in[i] = entry_rank_ff[i] + RANK_BITS'(1);
            end
            if (ins_onehot[i]) begin
               entry_valid_in[i] = 1'b1;
               entry_rank_in[i]  = '0;
            end
         end
      end
   end

   // Eviction plus insert leaves the count unchanged.
   assign occ_in = (do_insert && !do_evict) ? (occ_ff + COUNT_BITS'(1)) : occ_ff;

   assign key_we  = do_insert ? ins_onehot : '0;
   assign data_we = key_we | ((do_store && hit) ? match_vec : '0);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
         occ_ff         <= '0;
         cap_ff         <= lkvc_pkg::CAP_RESET;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_rank_ff[i] <= '0;
         end
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         entry_valid_ff <= entry_valid_in;
         occ_ff         <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            entry_rank_ff[i] <= entry_rank_in[i];
         end
         // Drop capacity writes while the cache holds entries.
         if (csr_wr_en && (occ_ff == '0)) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Payload registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff <= req_tuser;
         s1_key_ff  <= req_tdata[KEY_BITS-1:0];
         s1_sval_ff <= req_tdata[KEY_BITS +: VALUE_BITS];
         s1_fval_ff <= req_tdata[KEY_BITS + VALUE_BITS +: VALUE_BITS];
      end
      if (s1_fire && (s1_kind_ff == lkvc_pkg::KIND_LOOKUP)) begin
         rsp_hit_ff   <= hit;
         rsp_value_ff <= hit ? hit_value : s1_fval_ff;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (key_we[i]) begin
            entry_key_ff[i] <= s1_key_ff;
         end
         if (data_we[i]) begin
            entry_data_ff[i] <= s1_sval_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_BITS'(rsp_value_ff);

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `ASSERT_CLK(a_count_matches_valid, clock, reset,
      $countones(entry_valid_ff) == int'(occ_ff), "occupied count differs from valid bits")
   `ASSERT_CLK(a_unique_match, clock, reset,
      $onehot0(match_vec), "more than one entry matches the key")
   `ASSERT_NEVER(a_count_overflow, clock, reset,
      int'(occ_ff) > ENTRIES, "occupied count exceeds entry count")
   `ASSERT_CLK(a_idle_state_holds, clock, reset,
      !s1_valid_ff |=> $stable(occ_ff) && $stable(entry_valid_ff),
      "cache state changed without a transaction")

endmodule

[dv/lru_key_value_cache_tb.sv]
// Self-checking testbench for the LRU key-value cache: a directed table, then random traffic.
module lru_key_value_cache_tb;

   localparam int SLOTS         = lkvc_pkg::ENTRIES_DEFAULT;
   localparam int KEY_W         = lkvc_pkg::KEY_BITS_DEFAULT;
   localparam int VAL_W         = lkvc_pkg::VALUE_BITS_DEFAULT;
   localparam int CAP_W         = lkvc_pkg::CAP_BITS;
   localparam int REQ_W         = ((KEY_W + 2 * VAL_W + 7) / 8) * 8;
   localparam int RSP_W         = ((VAL_W + 7) / 8) * 8;
   localparam int RANK_W        = $clog2(SLOTS);
   // Wait for a lookup to pass the input and response registers after acceptance, with padding.
   localparam int SETTLE_CYCLES = 1 + 5;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int KEY_POOL      = 22;    // more keys than slots, so a full cache evicts
   localparam int HOLD_AT_ITEM  = 560;   // lands in the phase where the sender never idles
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int NUM_DIRECTED  = 19;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
   } read_result_type;

   typedef enum logic [1:0] {ROW_LOOKUP, ROW_STORE, ROW_CAPACITY} row_op_type;

   // One directed row; a capacity row carries the register value in the low key bits.
   typedef struct packed {
      row_op_type       op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] store_value;
      logic [VAL_W-1:0] fallback_value;
      logic             typed;
      read_result_type  result;
   } dir_row_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata;   // low bit up: key, store_value, fallback_value
   logic                req_tuser;   // kind
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RSP_W-1:0]    rsp_tdata;   // low bit up: read_value
   logic                rsp_tuser;   // hit
   logic                csr_wr_en;
   logic [CAP_W-1:0]    csr_wr_data;

   // Shadow copy of the cache contents and the capacity register
   logic                slot_valid [SLOTS];
   logic [KEY_W-1:0]    slot_key   [SLOTS];
   logic [VAL_W-1:0]    slot_value [SLOTS];
   logic [RANK_W-1:0]   slot_rank  [SLOTS];
   logic [CAP_W-1:0]    occupied;
   logic [CAP_W-1:0]    capacity;

   read_result_type     expected_reads [$];
   dir_row_type         directed_rows [NUM_DIRECTED];
   logic [KEY_W-1:0]    key_pool [KEY_POOL];
   int                  errors;
   int                  items_sent;
   int                  send_idle_pct;
   int                  recv_idle_pct;
   bit                  hold_done;
   int                  cycle_count;

   lru_key_value_cache u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Move slot s to rank 0; every slot that was more recent drops back one rank.
   function automatic void make_most_recent(input int s);
      logic [RANK_W-1:0] r;
      r = slot_rank[s];
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i] && slot_rank[i] < r)
            slot_rank[i]++;
      slot_rank[s] = '0;
   endfunction

   // Apply one accepted transaction to the shadow cache; return 1 when it yields a response.
   function automatic bit predict_access(input logic kind, input logic [KEY_W-1:0] k,
                                         input logic [VAL_W-1:0] sv, input logic [VAL_W-1:0] fv,
                                         output read_result_type res);
      int                  hit_slot;
      int                  free_slot;
      logic [CAP_W-1:0]    limit;
      hit_slot  = -1;
      free_slot = -1;
      res       = '0;
      for (int i = 0; i < SLOTS; i++)
         if (hit_slot < 0 && slot_valid[i] && slot_key[i] == k)
            hit_slot = i;

      if (kind == lkvc_pkg::KIND_LOOKUP) begin
         res.hit = (hit_slot >= 0);
         if (hit_slot >= 0) begin
            res.value = slot_value[hit_slot];
            make_most_recent(hit_slot);
         end else begin
            res.value = fv;
         end
         return 1'b1;
      end

      // Capacity above the slot count saturates; zero drops every store.
      limit = (capacity > SLOTS) ? CAP_W'(SLOTS) : capacity;
      if (limit == 0)
         return 1'b0;

      if (hit_slot >= 0) begin
         make_most_recent(hit_slot);
         slot_value[hit_slot] = sv;
         return 1'b0;
      end

      // Full: drop the least recent slot before inserting.
      if (occupied >= limit) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_rank[i] == occupied - 1'b1) begin
               slot_valid[i] = 1'b0;
               slot_rank[i]  = '0;
               occupied--;
               break;
            end
         end
      end

      for (int i = 0; i < SLOTS; i++)
         if (free_slot < 0 && !slot_valid[i])
            free_slot = i;
      if (free_slot < 0)
         return 1'b0;
      for (int i = 0; i < SLOTS; i++)
         if (slot_valid[i])
            slot_rank[i]++;
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot]   = k;
      slot_value[free_slot] = sv;
      slot_rank[free_slot]  = '0;
      occupied++;
      return 1'b0;
   endfunction

   // Offer one request transaction, idling first at random; predict on acceptance.
   // Leave req_tvalid high on return so back-to-back transactions need no second assignment.
   task automatic offer(input logic kind, input logic [KEY_W-1:0] k,
                        input logic [VAL_W-1:0] sv, input logic [VAL_W-1:0] fv,
                        output bit has_rsp, output read_result_type res);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {fv, sv, k};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      has_rsp = predict_access(kind, k, sv, fv, res);
      items_sent++;
   endtask

   // Stop offering and hold until every expected response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_reads.size() != 0)
         @(posedge clock);
   endtask

   // Write the capacity register only once the cache is quiet.
   task automatic write_capacity(input logic [CAP_W-1:0] v);
      drain_responses();
      // Stores give no response; let any trailing one settle.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      // The register takes the write only while the cache is empty.
      if (occupied == 0)
         capacity = v;
   endtask

   // Receiver: random backpressure, plus one long hold-off that fills the cache pipeline.
   initial begin : rsp_side
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Compare every response transaction with the oldest expectation, field by field.
   always @(posedge clock) begin : check_rsp
      read_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reads.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual hit=%0b value=%h",
                     $time, rsp_tuser, rsp_tdata);
         end else begin
            want = expected_reads.pop_front();
            if (rsp_tuser !== want.hit) begin
               errors++;
               $display("%0t: hit mismatch: expected %0b, actual %0b",
                        $time, want.hit, rsp_tuser);
            end
            if (rsp_tdata !== RSP_W'(want.value)) begin
               errors++;
               $display("%0t: read_value mismatch: expected %h, actual %h",
                        $time, want.value, rsp_tdata);
            end
         end
      end
   end

   // Watchdog: end the run if the traffic never completes.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : req_side
      logic             kind;
      logic [KEY_W-1:0] k;
      bit               has_rsp;
      read_result_type  res;

      // Drive every input from time zero and hold reset.
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= lkvc_pkg::KIND_LOOKUP;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      errors        = 0;
      items_sent    = 0;
      hold_done     = 1'b0;
      send_idle_pct = 14;
      recv_idle_pct = 51;

      // Shadow state after reset: empty cache, capacity at its reset value.
      for (int i = 0; i < SLOTS; i++) begin
         slot_valid[i] = 1'b0;
         slot_key[i]   = '0;
         slot_value[i] = '0;
         slot_rank[i]  = '0;
      end
      occupied = '0;
      capacity = lkvc_pkg::CAP_RESET;

      for (int i = 0; i < KEY_POOL; i++)
         key_pool[i] = $urandom;
      key_pool[0] = '0;
      key_pool[1] = '1;

      directed_rows = '{
         // empty cache: misses return the fallback
         '{ROW_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000}},
         '{ROW_LOOKUP,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'hFFFF_FFFF}},
         // capacity zero: the store is dropped
         '{ROW_CAPACITY, 32'h0000_0000, 32'h0,         32'h0,         1'b0, '0},
         '{ROW_STORE,    32'h0000_0005, 32'h1234_5678, 32'h0000_0000, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0005, 32'h0000_0000, 32'hA5A5_A5A5, 1'b1, '{1'b0, 32'hA5A5_A5A5}},
         // capacity above the slot count saturates
         '{ROW_CAPACITY, 32'h0000_001F, 32'h0,         32'h0,         1'b0, '0},
         '{ROW_STORE,    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
         '{ROW_STORE,    32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF}},
         '{ROW_LOOKUP,   32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 1'b1, '{1'b1, 32'h0000_0000}},
         // store hit overwrites the value
         '{ROW_STORE,    32'h0000_0000, 32'h5555_5555, 32'h0000_0000, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0000, 32'h0000_0000, 32'hAAAA_AAAA, 1'b1, '{1'b1, 32'h5555_5555}},
         // capacity write while not empty is ignored
         '{ROW_CAPACITY, 32'h0000_0001, 32'h0,         32'h0,         1'b0, '0},
         '{ROW_STORE,    32'h0000_0001, 32'h0000_0011, 32'h0000_0000, 1'b0, '0},
         '{ROW_STORE,    32'h0000_0002, 32'h0000_0022, 32'h0000_0000, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0007, 32'h0000_0000, 32'hDEAD_BEEF, 1'b1, '{1'b0, 32'hDEAD_BEEF}},
         '{ROW_LOOKUP,   32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
         '{ROW_LOOKUP,   32'h0000_0005, 32'h0000_0000, 32'h0000_0000, 1'b0, '0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; typed rows push their own expectation.
      for (int r = 0; r < NUM_DIRECTED; r++) begin
         if (directed_rows[r].op == ROW_CAPACITY) begin
            write_capacity(directed_rows[r].key[CAP_W-1:0]);
         end else begin
            kind = (directed_rows[r].op == ROW_STORE) ? lkvc_pkg::KIND_STORE
                                                      : lkvc_pkg::KIND_LOOKUP;
            offer(kind, directed_rows[r].key, directed_rows[r].store_value,
                  directed_rows[r].fallback_value, has_rsp, res);
            if (directed_rows[r].typed)
               expected_reads.push_back(directed_rows[r].result);
            else if (has_rsp)
               expected_reads.push_back(res);
         end
      end

      // Random traffic in three idling phases; pause for a full drain between them.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 14;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 14;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = ($urandom_range(0, 99) < 50) ? lkvc_pkg::KIND_STORE : lkvc_pkg::KIND_LOOKUP;
            // Mostly pooled keys for hits and evictions; the rest are fresh misses.
            k = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                             : KEY_W'($urandom);
            offer(kind, k, VAL_W'($urandom), VAL_W'($urandom), has_rsp, res);
            if (has_rsp)
               expected_reads.push_back(res);
         end
         drain_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
